/* hdl/csvfs_pkg.sv */
// Package with the shared types, constants and helpers of the CSV field splitter.
`timescale 1ns / 1ps
package csvfs_pkg;

   // Hard ceiling on buffered inner whitespace, so a flush plus its character
   // never exceeds 32 results for one input transaction.
   localparam int SPACE_STORE = 31;
   localparam int COUNT_W     = 5;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [1:0] {
      CMD_SPACE = 2'd0,
      CMD_CHAR  = 2'd1,
      CMD_CLOSE = 2'd2
   } cmd_op_type;

   // One unit of work for the back end. For CMD_SPACE, num is the buffer slot
   // to write; for CMD_CHAR, num is how many buffered spaces go out first.
   typedef struct packed {
      cmd_op_type        op;
      logic [7:0]        ch;
      logic [COUNT_W-1:0] num;
      logic              line;
      logic              ovf;
   } cmd_type;

   typedef enum logic {
      BK_IDLE  = 1'b0,
      BK_FLUSH = 1'b1
   } back_state_type;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage

/* hdl/csv_field_splitter.sv */
// Top level of the CSV field splitter: front end, command queue and back end.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_push / req_full  req_kind, req_char_in
//   rsp_      out        rsp_pop / rsp_empty  rsp_has_char, rsp_char_out, rsp_field_end,
//                                             rsp_line_end, rsp_space_overflow,
//                                             rsp_last_of_run
//
// The front end takes one character transaction per cycle while the four-entry
// command queue has room. The back end issues one result per cycle while the
// result register is free or being popped. A character with no buffered spaces
// ahead of it goes straight to the result register; a character that follows
// buffered inner spaces first starts a flush, then streams the spaces through
// the registered read of the whitespace buffer memory, and then issues the
// character itself. Buffering a space gives no result.
// Reset clears all control state; the whitespace buffer is not cleared,
// since only slots written in the current field are ever read.
// A stalled result side fills the command queue and then raises req_full.
//
// Each field is trimmed of leading and trailing whitespace. Inner whitespace is
// kept in a buffer of min(SPACE_DEPTH, 31) bytes; bytes beyond that are dropped and
// the field-end result carries the overflow flag.
module csv_field_splitter #(
   parameter int SPACE_DEPTH = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_kind,
   input  logic [7:0] req_char_in,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_has_char,
   output logic [7:0] rsp_char_out,
   output logic       rsp_field_end,
   output logic       rsp_line_end,
   output logic       rsp_space_overflow,
   output logic       rsp_last_of_run
);

   localparam int SPACE_LIMIT = (SPACE_DEPTH < csvfs_pkg::SPACE_STORE) ?
                                SPACE_DEPTH : csvfs_pkg::SPACE_STORE;

   logic               accept;
   logic               cmd_push;
   csvfs_pkg::cmd_type cmd;
   logic               q_full, q_empty, q_pop;
   csvfs_pkg::cmd_type q_head;

   // A transaction is taken whenever the queue has room; every character
   // produces at most one command, so one free slot is enough.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   csvfs_front #(
      .SPACE_LIMIT(SPACE_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_kind   (req_kind),
      .req_char_in(req_char_in),
      .cmd_push   (cmd_push),
      .cmd_out    (cmd)
   );

   csvfs_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(cmd),
      .full    (q_full),
      .empty   (q_empty),
      .head    (q_head),
      .pop     (q_pop)
   );

   csvfs_back #(
      .SPACE_LIMIT(SPACE_LIMIT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_has_char      (rsp_has_char),
      .rsp_char_out      (rsp_char_out),
      .rsp_field_end     (rsp_field_end),
      .rsp_line_end      (rsp_line_end),
      .rsp_space_overflow(rsp_space_overflow),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // The front end never writes a command into a full queue.
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command written into a full queue");

   // A waiting result is either a character or a field end, never both.
   a_char_xor_end: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_has_char != rsp_field_end))
      else $error("result is both a character and a field end");

   // A field end is always the final result of its transaction.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_field_end) |-> rsp_last_of_run)
      else $error("field end not marked as last of run");

   // Line end and overflow flags only appear on field-end results.
   a_flags_on_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_line_end || rsp_space_overflow)) |-> rsp_field_end)
      else $error("field-end flag on a character result");

endmodule

/* hdl/csvfs_front.sv */
// Front end: tracks quoting and field trimming state and turns each character into a command.
`timescale 1ns / 1ps
module csvfs_front #(
   parameter int SPACE_LIMIT = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                req_kind,
   input  logic [7:0]          req_char_in,
   output logic                cmd_push,
   output csvfs_pkg::cmd_type  cmd_out
);

   logic                            in_quotes_ff, in_quotes_in;
   logic                            quote_pending_ff, quote_pending_in;
   logic                            field_started_ff, field_started_in;
   logic [csvfs_pkg::COUNT_W-1:0]   space_count_ff, space_count_in;
   logic                            overflow_seen_ff, overflow_seen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff     <= 1'b0;
         quote_pending_ff <= 1'b0;
         field_started_ff <= 1'b0;
         space_count_ff   <= '0;
         overflow_seen_ff <= 1'b0;
      end else begin
         in_quotes_ff     <= in_quotes_in;
         quote_pending_ff <= quote_pending_in;
         field_started_ff <= field_started_in;
         space_count_ff   <= space_count_in;
         overflow_seen_ff <= overflow_seen_in;
      end
   end

   always_comb begin
      logic quoting;
      logic handled;
      logic is_content;
      logic do_close;
      quoting          = in_quotes_ff;
      handled          = 1'b0;
      is_content       = 1'b0;
      do_close         = 1'b0;
      in_quotes_in     = in_quotes_ff;
      quote_pending_in = quote_pending_ff;
      field_started_in = field_started_ff;
      space_count_in   = space_count_ff;
      overflow_seen_in = overflow_seen_ff;
      cmd_push         = 1'b0;
      cmd_out.op       = csvfs_pkg::CMD_CHAR;
      cmd_out.ch       = req_char_in;
      cmd_out.num      = '0;
      cmd_out.line     = req_kind;
      cmd_out.ovf      = overflow_seen_ff;

      if (accept) begin
         if (req_kind) begin
            quote_pending_in = 1'b0;
            quoting          = 1'b0;
            do_close         = 1'b1;
         end else begin
            // A pending quote is settled by this character: a second quote is
            // a literal quote, anything else ends the quoted section.
            if (quote_pending_ff) begin
               quote_pending_in = 1'b0;
               if (req_char_in == csvfs_pkg::CH_QUOTE) begin
                  is_content = 1'b1;
                  handled    = 1'b1;
               end else begin
                  quoting = 1'b0;
               end
            end
            if (!handled) begin
               if (req_char_in == csvfs_pkg::CH_QUOTE) begin
                  if (quoting) begin
                     quote_pending_in = 1'b1;
                  end else begin
                     quoting = 1'b1;
                  end
               end else if ((req_char_in == csvfs_pkg::CH_COMMA) && !quoting) begin
                  do_close = 1'b1;
               end else begin
                  is_content = 1'b1;
               end
            end
         end
         in_quotes_in = quoting;

         if (do_close) begin
            cmd_push         = 1'b1;
            cmd_out.op       = csvfs_pkg::CMD_CLOSE;
            field_started_in = 1'b0;
            space_count_in   = '0;
            overflow_seen_in = 1'b0;
         end else if (is_content) begin
            if (csvfs_pkg::is_space(req_char_in)) begin
               // Leading whitespace is dropped; inner whitespace is held back.
               if (field_started_ff) begin
                  if (space_count_ff < csvfs_pkg::COUNT_W'(SPACE_LIMIT)) begin
                     cmd_push       = 1'b1;
                     cmd_out.op     = csvfs_pkg::CMD_SPACE;
                     cmd_out.num    = space_count_ff;
                     space_count_in = space_count_ff + csvfs_pkg::COUNT_W'(1);
                  end else begin
                     overflow_seen_in = 1'b1;
                  end
               end
            end else begin
               cmd_push         = 1'b1;
               cmd_out.op       = csvfs_pkg::CMD_CHAR;
               cmd_out.num      = field_started_ff ? space_count_ff : '0;
               space_count_in   = '0;
               field_started_in = 1'b1;
            end
         end
      end
   end

endmodule

/* hdl/csvfs_cmd_queue.sv */
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module csvfs_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csvfs_pkg::cmd_type  push_cmd,
   output logic                full,
   output logic                empty,
   output csvfs_pkg::cmd_type  head,
   input  logic                pop
);

   csvfs_pkg::cmd_type               entry_ff [csvfs_pkg::QUEUE_DEPTH];
   logic [csvfs_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [csvfs_pkg::QCNT_W-1:0]     count_ff;
   logic                             do_push, do_pop;

   assign full    = (count_ff == csvfs_pkg::QCNT_W'(csvfs_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + csvfs_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + csvfs_pkg::QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + csvfs_pkg::QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - csvfs_pkg::QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/csvfs_back.sv */
// Back end: holds the whitespace buffer, runs flushes and drives the result register.
`timescale 1ns / 1ps
module csvfs_back #(
   parameter int SPACE_LIMIT = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  csvfs_pkg::cmd_type  q_head,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_has_char,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_field_end,
   output logic                rsp_line_end,
   output logic                rsp_space_overflow,
   output logic                rsp_last_of_run
);

   localparam int IDX_W = (SPACE_LIMIT > 1) ? $clog2(SPACE_LIMIT) : 1;

   logic [7:0]                      space_ram [SPACE_LIMIT];
   csvfs_pkg::back_state_type       state_ff, state_in;
   logic [csvfs_pkg::COUNT_W-1:0]   idx_ff, idx_in;
   logic                            rvalid_ff, rvalid_in;
   logic [7:0]                      rdata_ff;
   logic                            rd_en, wr_en;

   logic                            out_valid_ff;
   logic                            has_char_ff, has_char_in;
   logic [7:0]                      char_ff, char_in;
   logic                            field_end_ff, field_end_in;
   logic                            line_end_ff, line_end_in;
   logic                            ovf_ff, ovf_in;
   logic                            last_ff, last_in;
   logic                            out_load, out_free;

   assign out_free = !out_valid_ff || rsp_pop;

   always_comb begin
      logic r_taken;
      logic r_room;
      r_taken      = 1'b0;
      r_room       = 1'b0;
      state_in     = state_ff;
      idx_in       = idx_ff;
      rvalid_in    = rvalid_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      q_pop        = 1'b0;
      out_load     = 1'b0;
      has_char_in  = 1'b1;
      char_in      = q_head.ch;
      field_end_in = 1'b0;
      line_end_in  = 1'b0;
      ovf_in       = 1'b0;
      last_in      = 1'b1;

      unique case (state_ff)
         csvfs_pkg::BK_IDLE: begin
            if (!q_empty) begin
               unique case (q_head.op)
                  csvfs_pkg::CMD_SPACE: begin
                     wr_en = 1'b1;
                     q_pop = 1'b1;
                  end
                  csvfs_pkg::CMD_CHAR: begin
                     if (q_head.num == '0) begin
                        if (out_free) begin
                           out_load = 1'b1;
                           q_pop    = 1'b1;
                        end
                     end else begin
                        state_in = csvfs_pkg::BK_FLUSH;
                        idx_in   = '0;
                     end
                  end
                  csvfs_pkg::CMD_CLOSE: begin
                     if (out_free) begin
                        out_load     = 1'b1;
                        q_pop        = 1'b1;
                        has_char_in  = 1'b0;
                        char_in      = '0;
                        field_end_in = 1'b1;
                        line_end_in  = q_head.line;
                        ovf_in       = q_head.ovf;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         csvfs_pkg::BK_FLUSH: begin
            // Buffered spaces stream out through the registered read stage;
            // the character that triggered the flush follows the last one.
            if (rvalid_ff && out_free) begin
               out_load = 1'b1;
               char_in  = rdata_ff;
               last_in  = 1'b0;
               r_taken  = 1'b1;
            end
            r_room = !rvalid_ff || r_taken;
            if (idx_ff < q_head.num) begin
               if (r_room) begin
                  rd_en     = 1'b1;
                  rvalid_in = 1'b1;
                  idx_in    = idx_ff + csvfs_pkg::COUNT_W'(1);
               end
            end else begin
               if (r_taken) begin
                  rvalid_in = 1'b0;
               end
               if (!rvalid_ff && out_free) begin
                  out_load = 1'b1;
                  q_pop    = 1'b1;
                  state_in = csvfs_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = csvfs_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csvfs_pkg::BK_IDLE;
         idx_ff       <= '0;
         rvalid_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         rvalid_ff <= rvalid_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         space_ram[q_head.num[IDX_W-1:0]] <= q_head.ch;
      end
      if (rd_en) begin
         rdata_ff <= space_ram[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         has_char_ff  <= has_char_in;
         char_ff      <= char_in;
         field_end_ff <= field_end_in;
         line_end_ff  <= line_end_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_has_char       = has_char_ff;
   assign rsp_char_out       = char_ff;
   assign rsp_field_end      = field_end_ff;
   assign rsp_line_end       = line_end_ff;
   assign rsp_space_overflow = ovf_ff;
   assign rsp_last_of_run    = last_ff;

endmodule
